### design/mspc_pkg.sv
// shared types, constants and helpers for the motor speed pi controller
package mspc_pkg;

	localparam int DRV_W = 28;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int PRESET_MODE1 = 2000;
	localparam int PRESET_MODE2 = 2500;
	localparam int PRESET_MODE3 = 3100;
	localparam int CLAMP_MODE12 = 5500;
	localparam int CLAMP_MODE3 = 5000;
	localparam int LAUNCH_THRESHOLD_RST = 100;

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_TICK = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_LOW = 2'd1,
		MODE_MID = 2'd2,
		MODE_HIGH = 2'd3
	} speed_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_SPEED = 3'd0,
		REG_PROP_GAIN = 3'd1,
		REG_INT_GAIN = 3'd2,
		REG_SPEED_MODE = 3'd3,
		REG_LAUNCH_THRESHOLD = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic req_type;
		logic [15:0] left_pulses;
		logic left_forward;
		logic [15:0] right_pulses;
		logic right_forward;
		logic stop_request;
	} in_item_t;

	typedef struct packed {
		logic [15:0] drive_value;
		logic [15:0] measured_speed;
		logic closed_loop;
	} out_item_t;

	typedef struct packed {
		logic [15:0] target_speed;
		logic [15:0] prop_gain;
		logic [15:0] int_gain;
		logic [1:0] speed_mode;
		logic [14:0] launch_threshold;
	} cfg_t;

	typedef struct packed {
		logic [15:0] left_accum;
		logic [15:0] right_accum;
		logic [16:0] previous_error;
		logic [15:0] drive_reg;
		logic [15:0] speed_reg;
		logic closed_latch;
	} state_t;

	function automatic logic [15:0] sat16(input logic signed [DRV_W-1:0] v);
		logic [15:0] r;
		if (v > DRV_W'(32767)) begin
			r = 16'h7fff;
		end else if (v < -DRV_W'(32768)) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

### design/mspc_ifs.sv
// valid/ready channel interfaces for items, results and register writes
interface mspc_in_if;
	logic valid;
	logic ready;
	mspc_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mspc_out_if;
	logic valid;
	logic ready;
	mspc_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mspc_cfg_if;
	logic valid;
	logic ready;
	logic [mspc_pkg::CFG_IDX_W-1:0] index;
	logic [mspc_pkg::CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### design/mspc_cfg_regs.sv
// configuration register file
module mspc_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [mspc_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [mspc_pkg::CFG_DATA_W-1:0] wr_data,
	output mspc_pkg::cfg_t cfg
);

	mspc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed <= '0;
			cfg_q.prop_gain <= '0;
			cfg_q.int_gain <= '0;
			cfg_q.speed_mode <= mspc_pkg::MODE_OFF;
			cfg_q.launch_threshold <= 15'(mspc_pkg::LAUNCH_THRESHOLD_RST);
		end else if (wr_en) begin
			unique case (wr_index)
				mspc_pkg::REG_TARGET_SPEED: cfg_q.target_speed <= wr_data;
				mspc_pkg::REG_PROP_GAIN: cfg_q.prop_gain <= wr_data;
				mspc_pkg::REG_INT_GAIN: cfg_q.int_gain <= wr_data;
				mspc_pkg::REG_SPEED_MODE: cfg_q.speed_mode <= wr_data[1:0];
				mspc_pkg::REG_LAUNCH_THRESHOLD: cfg_q.launch_threshold <= wr_data[14:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/mspc_step.sv
// next-state logic: sample accumulation and control tick with pi update
module mspc_step (
	input mspc_pkg::in_item_t item,
	input mspc_pkg::state_t st,
	input mspc_pkg::cfg_t cfg,
	output mspc_pkg::state_t st_nxt
);

	localparam int W = mspc_pkg::DRV_W;

	logic signed [15:0] l_acc, r_acc, drive, target, kp, ki, speed;
	logic signed [16:0] prev_err, sp_sum, sp_adj, err, thr;
	logic signed [17:0] l_pls, r_pls, l_delta, r_delta, l_sum, r_sum, derr;
	logic signed [33:0] p_prod;
	logic signed [32:0] i_prod;
	logic signed [34:0] pi_sum, pi_adj;
	logic signed [26:0] step;
	logic signed [W-1:0] drv_pi, drv_open, drv_raw, drv_clamp, lim;
	logic launch, clamp_en;
	logic [15:0] drv_sat;

	assign l_acc = $signed(st.left_accum);
	assign r_acc = $signed(st.right_accum);
	assign drive = $signed(st.drive_reg);
	assign prev_err = $signed(st.previous_error);
	assign target = $signed(cfg.target_speed);
	assign kp = $signed(cfg.prop_gain);
	assign ki = $signed(cfg.int_gain);

	// sample path
	assign l_pls = $signed({2'b00, item.left_pulses});
	assign r_pls = $signed({2'b00, item.right_pulses});
	assign l_delta = item.left_forward ? l_pls : -l_pls;
	assign r_delta = item.right_forward ? -r_pls : r_pls;
	assign l_sum = 18'(l_acc) + l_delta;
	assign r_sum = 18'(r_acc) + r_delta;

	// speed average, truncated toward zero
	assign sp_sum = 17'(l_acc) + 17'(r_acc);
	assign sp_adj = sp_sum + $signed({16'b0, sp_sum[16]});
	assign speed = sp_adj[16:1];

	assign thr = $signed({2'b00, cfg.launch_threshold});
	assign launch = (17'(speed) < thr) && !st.closed_latch;

	// incremental pi
	assign err = 17'(target) - 17'(speed);
	assign derr = 18'(err) - 18'(prev_err);
	assign p_prod = kp * derr;
	assign i_prod = ki * err;
	assign pi_sum = 35'(p_prod) + 35'(i_prod);
	assign pi_adj = pi_sum + (pi_sum[34] ? 35'sd255 : 35'sd0);
	assign step = pi_adj[34:8];
	assign drv_pi = W'(drive) + W'(step);

	always_comb begin
		drv_open = W'(drive);
		if (!item.stop_request) begin
			case (cfg.speed_mode)
				mspc_pkg::MODE_LOW: drv_open = W'(mspc_pkg::PRESET_MODE1);
				mspc_pkg::MODE_MID: drv_open = W'(mspc_pkg::PRESET_MODE2);
				mspc_pkg::MODE_HIGH: drv_open = W'(mspc_pkg::PRESET_MODE3);
				default: drv_open = W'(drive);
			endcase
		end
	end

	assign drv_raw = launch ? drv_open : drv_pi;

	always_comb begin
		clamp_en = 1'b1;
		lim = W'(mspc_pkg::CLAMP_MODE12);
		case (cfg.speed_mode) inside
			mspc_pkg::MODE_LOW, mspc_pkg::MODE_MID: lim = W'(mspc_pkg::CLAMP_MODE12);
			mspc_pkg::MODE_HIGH: lim = W'(mspc_pkg::CLAMP_MODE3);
			default: clamp_en = 1'b0;
		endcase
	end

	always_comb begin
		drv_clamp = drv_raw;
		if (clamp_en) begin
			if (drv_raw > lim) begin
				drv_clamp = lim;
			end else if (drv_raw < -lim) begin
				drv_clamp = -lim;
			end
		end
	end

	assign drv_sat = mspc_pkg::sat16(drv_clamp);

	always_comb begin
		st_nxt = st;
		if (item.req_type == mspc_pkg::REQ_SAMPLE) begin
			st_nxt.left_accum = mspc_pkg::sat16(W'(l_sum));
			st_nxt.right_accum = mspc_pkg::sat16(W'(r_sum));
		end else begin
			st_nxt.left_accum = '0;
			st_nxt.right_accum = '0;
			st_nxt.speed_reg = speed;
			st_nxt.drive_reg = drv_sat;
			if (!launch) begin
				st_nxt.closed_latch = 1'b1;
				st_nxt.previous_error = err;
			end
		end
	end

endmodule

### design/motor_speed_pi_controller_core.sv
// top level of the two-wheel pi speed controller
// an accepted item passes the input register, then the result register, before its result is valid
// throughput: one item per cycle while results are taken; all state updates in a single combinational pass
// a held result does not block intake while the input register is free
// reset: arst_n clears state, both pipeline valids and config (launch threshold to 100)
module motor_speed_pi_controller_core (
	input logic clk,
	input logic arst_n,
	mspc_in_if.sink in_ch,
	mspc_out_if.source out_ch,
	mspc_cfg_if.sink cfg_ch
);

	mspc_pkg::cfg_t cfg;
	mspc_pkg::in_item_t item_s1;
	mspc_pkg::state_t state_q, state_nxt;
	mspc_pkg::out_item_t out_item_q;
	logic valid_s1, out_valid_q, advance, in_fire;

	assign cfg_ch.ready = 1'b1;

	mspc_cfg_regs u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.wr_en (cfg_ch.valid),
		.wr_index (cfg_ch.index),
		.wr_data (cfg_ch.wdata),
		.cfg (cfg)
	);

	mspc_step u_step (
		.item (item_s1),
		.st (state_q),
		.cfg (cfg),
		.st_nxt (state_nxt)
	);

	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.drive_value <= state_nxt.drive_reg;
			out_item_q.measured_speed <= state_nxt.speed_reg;
			out_item_q.closed_loop <= state_nxt.closed_latch;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_item_q;

endmodule

### design/mspc_checker.sv
// port-level checks for the speed controller, bound to the top level
module mspc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input mspc_pkg::out_item_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an accepted item is followed by a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no result two cycles after accept");

	// intake stalls only behind a blocked result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// closed loop never drops once latched
	a_latch_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.closed_loop |=> !out_valid || out_data.closed_loop)
		else $error("closed loop latch dropped");

endmodule

bind motor_speed_pi_controller_core mspc_checker u_mspc_checker (
	.clk (clk),
	.arst_n (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data (out_ch.data)
);
